// ===== sv/assert_macros.svh =====
// Assertion macros used by the blend core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising aclk edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Check an implication on every rising aclk edge while out of reset.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`endif

// ===== sv/fcb_pkg.sv =====
// Shared constants and types of the feathered clone-spot blend core.
package fcb_pkg;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int RADIUS_BITS      = 16;
    localparam int WEIGHT_BITS      = 17;
    localparam int SQRT_IN_BITS     = 48;
    localparam int SQRT_OUT_BITS    = 24;
    localparam logic [WEIGHT_BITS-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTRE_X        = 3'd0,
        REG_CENTRE_Y        = 3'd1,
        REG_SPOT_RADIUS     = 3'd2,
        REG_FEATHER_WIDTH   = 3'd3,
        REG_SOURCE_OFFSET_X = 3'd4,
        REG_SOURCE_OFFSET_Y = 3'd5
    } cfg_reg_t;
endpackage

// ===== sv/fcb_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module fcb_isqrt_pipe #(
    parameter int SIDE_BITS = 97
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [fcb_pkg::SQRT_IN_BITS-1:0]   in_rad,
    input  logic [SIDE_BITS-1:0]               in_side,
    output logic                               out_valid,
    output logic [fcb_pkg::SQRT_OUT_BITS-1:0]  out_root,
    output logic [SIDE_BITS-1:0]               out_side
);
    localparam int RB   = fcb_pkg::SQRT_IN_BITS;
    localparam int QB   = fcb_pkg::SQRT_OUT_BITS;
    localparam int REMB = QB + 3;

    logic [QB-1:0]        root_reg [QB];
    logic [REMB-1:0]      rem_reg  [QB];
    logic [RB-1:0]        rad_reg  [QB];
    logic [SIDE_BITS-1:0] side_reg [QB];
    logic                 vld_reg  [QB];
    logic [QB-1:0]        root_next [QB];
    logic [REMB-1:0]      rem_next  [QB];
    logic [RB-1:0]        rad_next  [QB];

    always_comb begin
        logic [QB-1:0]   p_root;
        logic [REMB-1:0] p_rem;
        logic [RB-1:0]   p_rad;
        logic [REMB-1:0] rem2;
        logic [REMB-1:0] trial;
        for (int k = 0; k < QB; k++) begin
            p_root = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k-1];
            p_rem  = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k-1];
            p_rad  = (k == 0) ? in_rad : rad_reg[(k == 0) ? 0 : k-1];
            rem2   = {p_rem[REMB-3:0], p_rad[RB-1:RB-2]};
            trial  = {1'b0, p_root, 2'b01};
            if (rem2 >= trial) begin
                rem_next[k]  = rem2 - trial;
                root_next[k] = {p_root[QB-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem2;
                root_next[k] = {p_root[QB-2:0], 1'b0};
            end
            rad_next[k] = {p_rad[RB-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QB; k++) begin
                root_reg[k] <= root_next[k];
                rem_reg[k]  <= rem_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QB; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < QB; k++)
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_root  = root_reg[QB-1];
    assign out_side  = side_reg[QB-1];
endmodule

// ===== sv/fcb_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module fcb_div_pipe #(
    parameter int DIV_BITS  = 16,
    parameter int Q_BITS    = 16,
    parameter int SIDE_BITS = 97
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_BITS-1:0]  in_rem,
    input  logic [Q_BITS-1:0]    in_low,
    input  logic [DIV_BITS-1:0]  divisor,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [Q_BITS-1:0]    out_quot,
    output logic [SIDE_BITS-1:0] out_side
);
    logic [DIV_BITS-1:0]  rem_reg  [Q_BITS];
    logic [Q_BITS-1:0]    low_reg  [Q_BITS];
    logic [Q_BITS-1:0]    q_reg    [Q_BITS];
    logic [SIDE_BITS-1:0] side_reg [Q_BITS];
    logic                 vld_reg  [Q_BITS];
    logic [DIV_BITS-1:0]  rem_next [Q_BITS];
    logic [Q_BITS-1:0]    low_next [Q_BITS];
    logic [Q_BITS-1:0]    q_next   [Q_BITS];

    always_comb begin
        logic [DIV_BITS-1:0] p_rem;
        logic [Q_BITS-1:0]   p_low;
        logic [Q_BITS-1:0]   p_q;
        logic [DIV_BITS:0]   rem2;
        for (int k = 0; k < Q_BITS; k++) begin
            p_rem = (k == 0) ? in_rem : rem_reg[(k == 0) ? 0 : k-1];
            p_low = (k == 0) ? in_low : low_reg[(k == 0) ? 0 : k-1];
            p_q   = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k-1];
            rem2  = {p_rem, p_low[Q_BITS-1]};
            if (rem2 >= {1'b0, divisor}) begin
                rem_next[k] = DIV_BITS'(rem2 - {1'b0, divisor});
                q_next[k]   = {p_q[Q_BITS-2:0], 1'b1};
            end else begin
                rem_next[k] = DIV_BITS'(rem2);
                q_next[k]   = {p_q[Q_BITS-2:0], 1'b0};
            end
            low_next[k] = {p_low[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q_BITS; k++) begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                q_reg[k]    <= q_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < Q_BITS; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < Q_BITS; k++)
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_valid = vld_reg[Q_BITS-1];
    assign out_quot  = q_reg[Q_BITS-1];
    assign out_side  = side_reg[Q_BITS-1];
endmodule

// ===== sv/feathered_spot_clone_blend_core.sv =====
// Top level of the feathered clone-spot blend core: config, distance, weight and blend.
// One pixel item enters per cycle while the output is not stalled; its result passes
// through 3 distance stages, 24 square-root stages, 16 stages for the radius divide, 1 band
// stage, 17 stages for the feather divide and 5 smoothstep and blend stages. The whole
// pipeline advances together whenever the output register is empty or being taken, so a
// stall on the result side freezes every stage and nothing is lost or repeated. Config
// writes are taken at once (cfg_ready is high) and must be made while the pipeline is
// empty; derived radius and feather terms are registered from the config registers. The
// source offsets are used only by the external pixel reader and are not kept here.
`include "assert_macros.svh"
module feathered_spot_clone_blend_core #(
    parameter int CHANNEL_BITS = fcb_pkg::CHANNEL_BITS_DEF,
    parameter int COORD_BITS   = fcb_pkg::COORD_BITS_DEF,
    localparam int IN_W  = ((2*COORD_BITS + 6*CHANNEL_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3*CHANNEL_BITS + fcb_pkg::WEIGHT_BITS + 1 + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_col, pixel_row, dest_red, dest_green, dest_blue, src_red, src_green, src_blue
    input  logic [IN_W-1:0]                    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red, out_green, out_blue, blend_weight, pixel_changed
    output logic [OUT_W-1:0]                   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fcb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    localparam int CB   = CHANNEL_BITS;
    localparam int CW   = COORD_BITS + 4;
    localparam int D2W  = 2*CW + 1;
    localparam int CMPW = (D2W > 32) ? D2W : 32;
    localparam int CHW  = 6*CB;
    localparam int SW   = CHW + 1;
    localparam int WB   = fcb_pkg::WEIGHT_BITS;
    localparam int RDB  = fcb_pkg::RADIUS_BITS;
    localparam int PW   = CB + WB;

    // Config registers and their derived terms.
    logic [CW-1:0]  centre_x_reg, centre_y_reg;
    logic [RDB-1:0] radius_reg;
    logic [WB-1:0]  feather_reg;
    logic [31:0]    r2_reg;
    logic [WB-1:0]  f_reg, inner_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= '0;
            feather_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (fcb_pkg::cfg_reg_t'(cfg_index)) inside
                fcb_pkg::REG_CENTRE_X:      centre_x_reg <= cfg_data[CW-1:0];
                fcb_pkg::REG_CENTRE_Y:      centre_y_reg <= cfg_data[CW-1:0];
                fcb_pkg::REG_SPOT_RADIUS:   radius_reg   <= cfg_data[RDB-1:0];
                fcb_pkg::REG_FEATHER_WIDTH: feather_reg  <= cfg_data[WB-1:0];
                // offsets belong to the pixel reader; drop them here
                fcb_pkg::REG_SOURCE_OFFSET_X, fcb_pkg::REG_SOURCE_OFFSET_Y: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        logic [WB-1:0] f_sat;
        f_sat     = (feather_reg > fcb_pkg::ONE_Q16) ? fcb_pkg::ONE_Q16 : feather_reg;
        r2_reg    <= radius_reg * radius_reg;
        f_reg     <= f_sat;
        inner_reg <= fcb_pkg::ONE_Q16 - f_sat;
    end

    // Global advance: move when the output register is free or being taken.
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Stage A: absolute coordinate differences.
    logic [COORD_BITS-1:0] col, row;
    logic [CW-1:0]  px, py;
    logic [CW-1:0]  dx_reg, dy_reg;
    logic [CHW-1:0] chan_a_reg, chan_b_reg;
    logic           vld_a_reg, vld_b_reg, vld_c_reg;

    assign col = s_tdata[COORD_BITS-1:0];
    assign row = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign px  = {col, 4'b0000};
    assign py  = {row, 4'b0000};

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg     <= (px >= centre_x_reg) ? px - centre_x_reg : centre_x_reg - px;
            dy_reg     <= (py >= centre_y_reg) ? py - centre_y_reg : centre_y_reg - py;
            chan_a_reg <= s_tdata[2*COORD_BITS+CHW-1:2*COORD_BITS];
        end
    end

    // Stage B: squares.
    logic [2*CW-1:0] dxx_reg, dyy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            dxx_reg    <= dx_reg * dx_reg;
            dyy_reg    <= dy_reg * dy_reg;
            chan_b_reg <= chan_a_reg;
        end
    end

    // Stage C: distance squared, in-spot test, radicand d2 * 65536.
    logic [D2W-1:0] d2;
    logic           in_spot;
    logic [fcb_pkg::SQRT_IN_BITS-1:0] rad_c_reg;
    logic [SW-1:0]  side_c_reg;
    assign d2      = D2W'(dxx_reg) + D2W'(dyy_reg);
    assign in_spot = CMPW'(d2) < CMPW'(r2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_c_reg  <= in_spot ? {32'(d2), 16'h0000} : '0;
            side_c_reg <= {in_spot, chan_b_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= s_tvalid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    // Square root of d2 * 65536.
    logic                              sq_vld;
    logic [fcb_pkg::SQRT_OUT_BITS-1:0] sq_root;
    logic [SW-1:0]                     sq_side;

    fcb_isqrt_pipe #(.SIDE_BITS(SW)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_c_reg), .in_rad(rad_c_reg), .in_side(side_c_reg),
        .out_valid(sq_vld), .out_root(sq_root), .out_side(sq_side)
    );

    // Normalize: (root << 8) / radius; the quotient fits 16 bits inside the spot.
    logic           nd_vld;
    logic [15:0]    nd_q;
    logic [SW-1:0]  nd_side;

    fcb_div_pipe #(.DIV_BITS(RDB), .Q_BITS(16), .SIDE_BITS(SW)) u_div_nd (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_vld), .in_rem(sq_root[23:8]), .in_low({sq_root[7:0], 8'h00}),
        .divisor(radius_reg), .in_side(sq_side),
        .out_valid(nd_vld), .out_quot(nd_q), .out_side(nd_side)
    );

    // Stage D: position within the feather band.
    logic [WB-1:0] nd;
    logic [WB-1:0] diff_d_reg;
    logic [SW-1:0] side_d_reg;
    logic          vld_d_reg;
    assign nd = nd_side[SW-1] ? {1'b0, nd_q} : fcb_pkg::ONE_Q16;

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_d_reg <= (nd > inner_reg) ? nd - inner_reg : '0;
            side_d_reg <= nd_side;
        end
    end

    // Feather divide: t = (diff << 16) / f, never above one.
    logic          t_vld;
    logic [WB-1:0] t_q;
    logic [SW-1:0] t_side;

    fcb_div_pipe #(.DIV_BITS(WB), .Q_BITS(WB), .SIDE_BITS(SW)) u_div_t (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vld_d_reg), .in_rem({1'b0, diff_d_reg[WB-1:1]}),
        .in_low({diff_d_reg[0], 16'h0000}),
        .divisor(f_reg), .in_side(side_d_reg),
        .out_valid(t_vld), .out_quot(t_q), .out_side(t_side)
    );

    // Stages E to G: smoothstep and weight.
    logic [2*WB-1:0] tt_e_reg;
    logic [17:0]     k_e_reg;
    logic [51:0]     prod_f_reg;
    logic [WB-1:0]   w_g_reg;
    logic [SW-1:0]   side_e_reg, side_f_reg, side_g_reg;
    logic            vld_e_reg, vld_f_reg, vld_g_reg;
    logic [WB-1:0]   s_val;
    logic [WB-1:0]   w_val;

    assign s_val = WB'((prod_f_reg + 52'h0_0000_8000_0000) >> 32);

    always_comb begin
        if (radius_reg == '0) begin
            w_val = '0;
        end else if (f_reg == '0) begin
            w_val = side_f_reg[SW-1] ? fcb_pkg::ONE_Q16 : '0;
        end else begin
            w_val = fcb_pkg::ONE_Q16 - s_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tt_e_reg   <= t_q * t_q;
            k_e_reg    <= 18'd196608 - {t_q, 1'b0};
            side_e_reg <= t_side;
            prod_f_reg <= tt_e_reg * k_e_reg;
            side_f_reg <= side_e_reg;
            w_g_reg    <= w_val;
            side_g_reg <= side_f_reg;
        end
    end

    // Stage H: channel products.
    logic [PW-1:0] pd_h_reg [3];
    logic [PW-1:0] ps_h_reg [3];
    logic [WB-1:0] w_h_reg;
    logic          vld_h_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                pd_h_reg[c] <= side_g_reg[c*CB +: CB] * (fcb_pkg::ONE_Q16 - w_g_reg);
                ps_h_reg[c] <= side_g_reg[(3+c)*CB +: CB] * w_g_reg;
            end
            w_h_reg <= w_g_reg;
        end
    end

    // Stage I: rounded sum into the output register.
    logic [3*CB-1:0] chan_out_reg;
    logic [WB-1:0]   w_out_reg;

    always_ff @(posedge aclk) begin
        logic [PW:0] acc;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                acc = {1'b0, pd_h_reg[c]} + {1'b0, ps_h_reg[c]} + (PW+1)'(32768);
                chan_out_reg[c*CB +: CB] <= acc[CB+15:16];
            end
            w_out_reg <= w_h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_d_reg   <= 1'b0;
            vld_e_reg   <= 1'b0;
            vld_f_reg   <= 1'b0;
            vld_g_reg   <= 1'b0;
            vld_h_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_d_reg   <= nd_vld;
            vld_e_reg   <= t_vld;
            vld_f_reg   <= vld_e_reg;
            vld_g_reg   <= vld_f_reg;
            vld_h_reg   <= vld_g_reg;
            out_vld_reg <= vld_h_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({(w_out_reg != '0), w_out_reg, chan_out_reg});

    `ASSERT_IMPL(a_changed_flag, m_tvalid,
        m_tdata[3*CB+WB] == (m_tdata[3*CB+WB-1:3*CB] != '0), "changed flag mismatch")
    `ASSERT_IMPL(a_weight_range, m_tvalid,
        m_tdata[3*CB+WB-1:3*CB] <= fcb_pkg::ONE_Q16, "weight above one")
    `ASSERT_IMPL(a_zero_radius, m_tvalid && (radius_reg == '0),
        m_tdata[3*CB+WB-1:3*CB] == '0, "weight with zero radius")
endmodule
